FILE: src/knps_pkg.sv
// knps_pkg: shared constants, request/status codes and the controller/datapath
// command and status structs for the k-nearest point search unit.
// Depends on nothing; used by every module of the block except knps_ram.
`default_nettype none

package knps_pkg;

    localparam int MAX_POINTS = 64;
    localparam int K_MAX      = 8;
    localparam int COORD_BITS = 12;

    localparam int IDX_BITS   = $clog2(MAX_POINTS);
    localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
    localparam int K_BITS     = $clog2(K_MAX + 1);
    localparam int NUM_BITS   = (CNT_BITS > K_BITS) ? CNT_BITS : K_BITS;
    localparam int SQ_BITS    = 2 * COORD_BITS;
    localparam int DIST_BITS  = 2 * COORD_BITS + 1;
    localparam int PT_BITS    = 2 * COORD_BITS;

    localparam int REQ_BITS   = 2;
    localparam int STAT_BITS  = 2;
    localparam int KIN_BITS   = 4;

    localparam logic [REQ_BITS-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_BITS-1:0] REQ_QUERY  = 2'd1;
    localparam logic [REQ_BITS-1:0] REQ_CLEAR  = 2'd2;

    localparam logic [STAT_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_BITS-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_BITS-1:0] ST_BADQ  = 2'd2;
    localparam logic [STAT_BITS-1:0] ST_SHORT = 2'd3;

    typedef struct packed {
        logic                  ram_we;
        logic [IDX_BITS-1:0]   ram_addr;
        logic                  scan_valid;
        logic                  q_load;
        logic                  mask_clr;
        logic                  mask_set;
        logic                  best_clr;
        logic                  out_load;
        logic                  out_use_best;
        logic [IDX_BITS-1:0]   out_idx;
        logic [STAT_BITS-1:0]  out_status;
        logic                  out_last;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
        logic pipe_busy;
    } t_stat;

endpackage

`default_nettype wire

FILE: src/k_nearest_point_search_unit.sv
// k_nearest_point_search_unit: top level of the k-nearest point search block.
// Depends on knps_pkg, knps_ctrl and knps_dp (which holds knps_ram).
//
// Usage:
//   Request channel i_valid/o_ready carries one word: i_req_type selects insert,
//   query or clear; i_point_x/i_point_y give an inserted point; i_query_index
//   and i_k_count give a query. Result channel o_valid/i_ready returns words
//   of o_result_index, o_result_dist, o_status and o_last (set on the final
//   word of a request). Request code 3 is taken and gives no word.
//   Insert, clear, bad-index and no-neighbor requests give one word in the cycle
//   after acceptance; back-to-back inserts run at one per cycle while the
//   receiver keeps up.
//   A query reads the query point (S_QRD, S_QCAP), then for each of the n neighbors
//   scans every stored point through the single store port, one per cycle,
//   drains the distance pipeline and emits one word in S_EMIT. The scan over
//   the one read port sets the length of a query.
//   Reset empties the store (count to zero); point data is not cleared.
//   A stalled receiver holds the pending word; a new request or the next
//   neighbor waits until that word is taken.
`default_nettype none

module k_nearest_point_search_unit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic [knps_pkg::REQ_BITS-1:0]       i_req_type,
    input  wire logic [knps_pkg::COORD_BITS-1:0]     i_point_x,
    input  wire logic [knps_pkg::COORD_BITS-1:0]     i_point_y,
    input  wire logic [knps_pkg::IDX_BITS-1:0]       i_query_index,
    input  wire logic [knps_pkg::KIN_BITS-1:0]       i_k_count,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic      [knps_pkg::IDX_BITS-1:0]       o_result_index,
    output logic      [knps_pkg::DIST_BITS-1:0]      o_result_dist,
    output logic      [knps_pkg::STAT_BITS-1:0]      o_status,
    output logic                                     o_last
);

    knps_pkg::t_cmd  cmd;
    knps_pkg::t_stat stat;

    knps_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_req_type    (i_req_type),
        .i_query_index (i_query_index),
        .i_k_count     (i_k_count),
        .i_stat        (stat),
        .o_cmd         (cmd)
    );

    knps_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_result_index (o_result_index),
        .o_result_dist  (o_result_dist),
        .o_status       (o_status),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire

FILE: src/knps_ram.sv
// knps_ram: generic single-port RAM, write and registered read at one address.
// No dependencies.
`default_nettype none

module knps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: src/knps_dp.sv
// knps_dp: point store, distance pipeline, best tracker, chosen mask and
// output word register. Depends on knps_pkg and knps_ram.
`default_nettype none

module knps_dp (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire knps_pkg::t_cmd                      i_cmd,
    output knps_pkg::t_stat                          o_stat,
    input  wire logic [knps_pkg::COORD_BITS-1:0]     i_point_x,
    input  wire logic [knps_pkg::COORD_BITS-1:0]     i_point_y,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic      [knps_pkg::IDX_BITS-1:0]       o_result_index,
    output logic      [knps_pkg::DIST_BITS-1:0]      o_result_dist,
    output logic      [knps_pkg::STAT_BITS-1:0]      o_status,
    output logic                                     o_last
);

    localparam int CB = knps_pkg::COORD_BITS;

    logic [knps_pkg::PT_BITS-1:0]   rdata;
    logic [CB-1:0]                  rd_x, rd_y, dx, dy;
    logic [knps_pkg::DIST_BITS-1:0] cand_dist;
    logic                           s1_cand;

    logic [CB-1:0]                  r_qx, r_qy;
    logic                           r_s1_valid, r_s2_valid;
    logic [knps_pkg::IDX_BITS-1:0]  r_s1_idx, r_s2_idx;
    logic [knps_pkg::SQ_BITS-1:0]   r_sqx, r_sqy;
    logic                           r_found;
    logic [knps_pkg::IDX_BITS-1:0]  r_best_idx;
    logic [knps_pkg::DIST_BITS-1:0] r_best_dist;
    logic [knps_pkg::MAX_POINTS-1:0] r_mask;
    logic                           r_out_valid;
    logic [knps_pkg::IDX_BITS-1:0]  r_out_idx;
    logic [knps_pkg::DIST_BITS-1:0] r_out_dist;
    logic [knps_pkg::STAT_BITS-1:0] r_out_status;
    logic                           r_out_last;

    knps_ram #(
        .WIDTH (knps_pkg::PT_BITS),
        .DEPTH (knps_pkg::MAX_POINTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ram_we),
        .i_addr  (i_cmd.ram_addr),
        .i_wdata ({i_point_x, i_point_y}),
        .o_rdata (rdata)
    );

    assign rd_x      = rdata[knps_pkg::PT_BITS-1:CB];
    assign rd_y      = rdata[CB-1:0];
    assign dx        = (rd_x > r_qx) ? (rd_x - r_qx) : (r_qx - rd_x);
    assign dy        = (rd_y > r_qy) ? (rd_y - r_qy) : (r_qy - rd_y);
    assign s1_cand   = r_s1_valid && !r_mask[r_s1_idx];
    assign cand_dist = knps_pkg::DIST_BITS'(r_sqx) + knps_pkg::DIST_BITS'(r_sqy);

    // query point capture and product stage
    always_ff @(posedge i_clk) begin
        if (i_cmd.q_load) begin
            r_qx <= rd_x;
            r_qy <= rd_y;
        end
        r_s1_idx <= i_cmd.ram_addr;
        r_s2_idx <= r_s1_idx;
        r_sqx    <= knps_pkg::SQ_BITS'(dx) * knps_pkg::SQ_BITS'(dx);
        r_sqy    <= knps_pkg::SQ_BITS'(dy) * knps_pkg::SQ_BITS'(dy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_found    <= 1'b0;
            r_mask     <= '0;
        end else begin
            r_s1_valid <= i_cmd.scan_valid;
            r_s2_valid <= s1_cand;
            if (i_cmd.best_clr) begin
                r_found <= 1'b0;
            end else if (r_s2_valid && (!r_found || cand_dist < r_best_dist)) begin
                // strict compare: ascending scan keeps the lower index on ties
                r_found <= 1'b1;
            end
            if (i_cmd.mask_clr) begin
                r_mask <= '0;
            end else if (i_cmd.mask_set) begin
                r_mask[r_best_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_cmd.best_clr && r_s2_valid && (!r_found || cand_dist < r_best_dist)) begin
            r_best_idx  <= r_s2_idx;
            r_best_dist <= cand_dist;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_idx    <= i_cmd.out_use_best ? r_best_idx : i_cmd.out_idx;
            r_out_dist   <= i_cmd.out_use_best ? r_best_dist : '0;
            r_out_status <= i_cmd.out_status;
            r_out_last   <= i_cmd.out_last;
        end
    end

    assign o_stat.out_busy  = r_out_valid && !i_ready;
    assign o_stat.pipe_busy = r_s1_valid || r_s2_valid;

    assign o_valid        = r_out_valid;
    assign o_result_index = r_out_idx;
    assign o_result_dist  = r_out_dist;
    assign o_status       = r_out_status;
    assign o_last         = r_out_last;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_ready))
        else $error("output word overwritten before it was taken");

    a_emit_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mask_set |-> (r_found && !r_mask[r_best_idx]))
        else $error("neighbor emitted without a fresh best candidate");

    a_pipe_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid |-> $past(r_s1_valid))
        else $error("distance stage valid without a read before it");

endmodule

`default_nettype wire

FILE: src/knps_ctrl.sv
// knps_ctrl: request decode, point count and the query sequencer (scan rounds,
// drain, emit). Drives knps_dp through knps_pkg::t_cmd; depends on knps_pkg.
`default_nettype none

module knps_ctrl (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic [knps_pkg::REQ_BITS-1:0]      i_req_type,
    input  wire logic [knps_pkg::IDX_BITS-1:0]      i_query_index,
    input  wire logic [knps_pkg::KIN_BITS-1:0]      i_k_count,
    input  wire knps_pkg::t_stat                    i_stat,
    output knps_pkg::t_cmd                          o_cmd
);

    localparam int IB = knps_pkg::IDX_BITS;
    localparam int CB = knps_pkg::CNT_BITS;
    localparam int KB = knps_pkg::K_BITS;
    localparam int NB = knps_pkg::NUM_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_QRD,
        S_QCAP,
        S_SCAN,
        S_DRAIN,
        S_EMIT
    } t_state;

    t_state          r_state, n_state;
    logic [CB-1:0]   r_count, n_count;
    logic [IB-1:0]   r_q, n_q;
    logic [KB-1:0]   r_n, n_n;
    logic [KB-1:0]   r_round, n_round;
    logic [CB-1:0]   r_scan, n_scan;
    logic            r_short, n_short;

    logic            accept;
    logic [KB-1:0]   k_eff;
    logic [NB-1:0]   avail, n_take;
    logic            is_last;

    always_comb begin
        if (i_k_count == '0) begin
            k_eff = KB'(1);
        end else if (32'(i_k_count) > knps_pkg::K_MAX) begin
            k_eff = KB'(knps_pkg::K_MAX);
        end else begin
            k_eff = KB'(i_k_count);
        end
        avail  = NB'(r_count) - NB'(1);
        n_take = (NB'(k_eff) < avail) ? NB'(k_eff) : avail;
    end

    assign o_ready = (r_state == S_IDLE) && !i_stat.out_busy;
    assign accept  = i_valid && o_ready;
    assign is_last = (r_round == r_n - KB'(1));

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_q     = r_q;
        n_n     = r_n;
        n_round = r_round;
        n_scan  = r_scan;
        n_short = r_short;
        o_cmd   = '0;
        o_cmd.ram_addr = r_count[IB-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_req_type)
                        knps_pkg::REQ_INSERT: begin
                            o_cmd.out_load = 1'b1;
                            o_cmd.out_last = 1'b1;
                            if (32'(r_count) >= knps_pkg::MAX_POINTS) begin
                                o_cmd.out_status = knps_pkg::ST_FULL;
                            end else begin
                                o_cmd.ram_we     = 1'b1;
                                o_cmd.out_idx    = r_count[IB-1:0];
                                o_cmd.out_status = knps_pkg::ST_OK;
                                n_count          = r_count + CB'(1);
                            end
                        end
                        knps_pkg::REQ_CLEAR: begin
                            o_cmd.out_load   = 1'b1;
                            o_cmd.out_last   = 1'b1;
                            o_cmd.out_status = knps_pkg::ST_OK;
                            n_count          = '0;
                        end
                        knps_pkg::REQ_QUERY: begin
                            if (CB'(i_query_index) >= r_count) begin
                                o_cmd.out_load   = 1'b1;
                                o_cmd.out_last   = 1'b1;
                                o_cmd.out_status = knps_pkg::ST_BADQ;
                            end else if (n_take == '0) begin
                                o_cmd.out_load   = 1'b1;
                                o_cmd.out_last   = 1'b1;
                                o_cmd.out_status = knps_pkg::ST_SHORT;
                            end else begin
                                n_q     = i_query_index;
                                n_n     = KB'(n_take);
                                n_short = (NB'(k_eff) != n_take);
                                n_round = '0;
                                n_state = S_QRD;
                            end
                        end
                        default: begin
                            // unused request code: taken and dropped
                        end
                    endcase
                end
            end
            S_QRD: begin
                o_cmd.ram_addr = r_q;
                n_state        = S_QCAP;
            end
            S_QCAP: begin
                o_cmd.q_load   = 1'b1;
                o_cmd.mask_clr = 1'b1;
                o_cmd.best_clr = 1'b1;
                n_scan         = '0;
                n_state        = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.ram_addr   = r_scan[IB-1:0];
                o_cmd.scan_valid = (r_scan[IB-1:0] != r_q);
                n_scan           = r_scan + CB'(1);
                if (r_scan == r_count - CB'(1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_stat.pipe_busy) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_load     = 1'b1;
                    o_cmd.out_use_best = 1'b1;
                    o_cmd.mask_set     = 1'b1;
                    o_cmd.out_last     = is_last;
                    o_cmd.out_status   = (is_last && r_short) ? knps_pkg::ST_SHORT
                                                              : knps_pkg::ST_OK;
                    if (is_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.best_clr = 1'b1;
                        n_round        = r_round + KB'(1);
                        n_scan         = '0;
                        n_state        = S_SCAN;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_q     <= '0;
            r_n     <= '0;
            r_round <= '0;
            r_scan  <= '0;
            r_short <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_q     <= n_q;
            r_n     <= n_n;
            r_round <= n_round;
            r_scan  <= n_scan;
            r_short <= n_short;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= knps_pkg::MAX_POINTS)
        else $error("point count beyond store depth");

    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.ram_we |-> (r_state == S_IDLE && 32'(r_count) < knps_pkg::MAX_POINTS))
        else $error("store written outside an insert");

    a_round_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_round < r_n))
        else $error("query round beyond neighbor count");

endmodule

`default_nettype wire
